// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL of the triplet sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk while reset is released.
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int SUM_W       = CNT_W + 1;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 16;
    localparam int VAL_W       = 64;
    localparam int KEY_W       = ROW_W + COL_W;
    localparam int ENT_W       = KEY_W + VAL_W;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             command;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [VAL_W-1:0] out_value;
        logic             last;
        status_t          status;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_SET,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_RD_MEM,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic out_full;
        logic out_empty;
        logic sort_start;
        logic read_start;
        logic run_set;
        logic merge_rd;
        logic merge_step;
        logic run_next;
        logic read_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sorted;
        logic full;
        logic read_empty;
        logic trivial;
        logic run_end;
        logic pass_end;
        logic sort_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sts_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module sts_ctrl
    import sts_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       command,
    output logic            s_ready,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    if (command == CMD_LOAD) begin
                        if (sts.full) begin
                            cmd.out_full = 1'b1;
                        end else begin
                            cmd.load = 1'b1;
                        end
                    end else if (sts.read_empty) begin
                        cmd.out_empty = 1'b1;
                    end else if (sts.sorted) begin
                        state_next = ST_RD_MEM;
                    end else if (sts.trivial) begin
                        cmd.read_start = 1'b1;
                        state_next     = ST_RD_MEM;
                    end else begin
                        cmd.sort_start = 1'b1;
                        state_next     = ST_RUN_SET;
                    end
                end
            end
            ST_RUN_SET: begin
                cmd.run_set = 1'b1;
                state_next  = ST_MRG_RD;
            end
            ST_MRG_RD: begin
                cmd.merge_rd = 1'b1;
                state_next   = ST_MRG_WR;
            end
            ST_MRG_WR: begin
                cmd.merge_rd   = 1'b1;
                cmd.merge_step = 1'b1;
                if (sts.run_end) begin
                    cmd.run_next = 1'b1;
                    if (sts.pass_end && sts.sort_done) begin
                        cmd.read_start = 1'b1;
                        state_next     = ST_RD_MEM;
                    end else begin
                        state_next = ST_RUN_SET;
                    end
                end else begin
                    state_next = ST_MRG_RD;
                end
            end
            ST_RD_MEM: begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (sts.out_free) begin
                    cmd.read_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_SYNC(a_rd_then_wr, (state_reg == ST_MRG_RD) |=> (state_reg == ST_MRG_WR), "merge read not followed by write")
    `ASSERT_NEVER(a_accept_busy, s_ready && (state_reg != ST_IDLE), "transaction taken while busy")
    `ASSERT_NEVER(a_load_in_sort, cmd.load && (cmd.merge_step || cmd.read_out), "load during sort or read")

endmodule

`default_nettype wire

// ===== hw/rtl/sts_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

module sts_dp
    import sts_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    input  wire in_t       s_data,
    output out_t           m_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     sts
);

    logic [ENT_W-1:0] mem0 [MAX_ENTRIES];
    logic [ENT_W-1:0] mem1 [MAX_ENTRIES];

    logic             dbl_reg;
    logic [CNT_W-1:0] count_reg, rp_reg, w_reg, lo_reg, mid_reg, hi_reg;
    logic [CNT_W-1:0] i_reg, j_reg, k_reg;
    logic             sorted_reg, src_reg;
    logic [ENT_W-1:0] qa_reg, qb_reg;
    out_t             out_reg;
    logic             m_valid_reg;

    logic [CNT_W-1:0] count_eff;
    logic [SUM_W-1:0] mid_sum, hi_sum, k_inc;
    logic [CNT_W-1:0] mid_next, hi_next;
    logic [IDX_W-1:0] addr_a, addr_b;
    logic [ENT_W-1:0] load_ent, merge_ent;
    logic             take_left;
    logic [VAL_W-1:0] load_val;

    assign count_eff = sorted_reg ? '0 : count_reg;
    assign mid_sum   = SUM_W'(lo_reg) + SUM_W'(w_reg);
    assign hi_sum    = SUM_W'(lo_reg) + (SUM_W'(w_reg) << 1);
    assign mid_next  = (mid_sum > SUM_W'(count_reg)) ? count_reg : mid_sum[CNT_W-1:0];
    assign hi_next   = (hi_sum > SUM_W'(count_reg)) ? count_reg : hi_sum[CNT_W-1:0];
    assign k_inc     = SUM_W'(k_reg) + SUM_W'(1);
    assign addr_a    = cmd.merge_rd ? i_reg[IDX_W-1:0] : rp_reg[IDX_W-1:0];
    assign addr_b    = j_reg[IDX_W-1:0];
    assign load_val  = dbl_reg ? s_data.value : {32'd0, s_data.value[31:0]};
    assign load_ent  = {s_data.row, s_data.col, load_val};

    // Stable merge: the left run wins ties.
    assign take_left = (i_reg < mid_reg)
                    && ((j_reg >= hi_reg)
                        || (qa_reg[ENT_W-1 -: KEY_W] <= qb_reg[ENT_W-1 -: KEY_W]));
    assign merge_ent = take_left ? qa_reg : qb_reg;

    assign sts.sorted     = sorted_reg;
    assign sts.full       = (count_eff == CNT_W'(MAX_ENTRIES));
    assign sts.read_empty = sorted_reg ? (rp_reg >= count_reg) : (count_reg == '0);
    assign sts.trivial    = (count_reg <= CNT_W'(1));
    assign sts.run_end    = (k_inc == SUM_W'(hi_reg));
    assign sts.pass_end   = (hi_reg == count_reg);
    assign sts.sort_done  = ((SUM_W'(w_reg) << 1) >= SUM_W'(count_reg));
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem0[count_eff[IDX_W-1:0]] <= load_ent;
        end else if (cmd.merge_step && src_reg) begin
            mem0[k_reg[IDX_W-1:0]] <= merge_ent;
        end
        if (cmd.merge_step && !src_reg) begin
            mem1[k_reg[IDX_W-1:0]] <= merge_ent;
        end
        qa_reg <= src_reg ? mem1[addr_a] : mem0[addr_a];
        qb_reg <= src_reg ? mem1[addr_b] : mem0[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbl_reg     <= 1'b1;
            count_reg   <= '0;
            rp_reg      <= '0;
            sorted_reg  <= 1'b0;
            src_reg     <= 1'b0;
            w_reg       <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dbl_reg <= cfg_wdata;
            end
            if (cmd.out_full || cmd.out_empty || cmd.read_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                count_reg  <= count_eff + CNT_W'(1);
                rp_reg     <= '0;
                sorted_reg <= 1'b0;
                src_reg    <= 1'b0;
            end
            if (cmd.sort_start) begin
                w_reg  <= CNT_W'(1);
                lo_reg <= '0;
            end
            if (cmd.run_set) begin
                mid_reg <= mid_next;
                hi_reg  <= hi_next;
                i_reg   <= lo_reg;
                j_reg   <= mid_next;
                k_reg   <= lo_reg;
            end
            if (cmd.merge_step) begin
                k_reg <= k_reg + CNT_W'(1);
                if (take_left) begin
                    i_reg <= i_reg + CNT_W'(1);
                end else begin
                    j_reg <= j_reg + CNT_W'(1);
                end
            end
            if (cmd.run_next) begin
                if (hi_reg == count_reg) begin
                    lo_reg  <= '0;
                    w_reg   <= w_reg << 1;
                    src_reg <= !src_reg;
                end else begin
                    lo_reg <= hi_reg;
                end
            end
            if (cmd.read_start) begin
                sorted_reg <= 1'b1;
                rp_reg     <= '0;
            end
            if (cmd.read_out) begin
                rp_reg <= rp_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_full) begin
            out_reg <= {{(ENT_W + 1){1'b0}}, STATUS_FULL};
        end else if (cmd.out_empty) begin
            out_reg <= {{(ENT_W + 1){1'b0}}, STATUS_EMPTY};
        end else if (cmd.read_out) begin
            out_reg.out_row   <= qa_reg[ENT_W-1 -: ROW_W];
            out_reg.out_col   <= qa_reg[VAL_W +: COL_W];
            out_reg.out_value <= qa_reg[VAL_W-1:0];
            out_reg.last      <= (rp_reg + CNT_W'(1) == count_reg);
            out_reg.status    <= STATUS_OK;
        end
    end

    `ASSERT_SYNC(a_rp_bound, rp_reg <= count_reg, "read pointer beyond batch")
    `ASSERT_SYNC(a_cnt_bound, count_reg <= CNT_W'(MAX_ENTRIES), "entry count beyond store")
    `ASSERT_SYNC(a_merge_ptrs, (SUM_W'(k_reg) + SUM_W'(mid_reg)) == (SUM_W'(i_reg) + SUM_W'(j_reg)), "merge pointers out of step")

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_triplet_row_col_sort.sv =====
`default_nettype none

// Sorts a batch of sparse-matrix triplets (row, column, payload) into row-major order, row
// first and column second, keeping load order among equal (row, column) pairs. Send load
// transactions (command 0) to fill a store of up to 1024 triplets; each load returns
// nothing, unless the store is full, when the triplet is dropped and a result with status 1
// comes back. The first read transaction (command 1) sorts the batch with a bottom-up
// stable merge sort that ping-pongs between two triplet memories: ceil(log2 n) passes over
// the n elements, each element taking a memory read and then a compare and write, plus a
// run-setup step for each run. Every read then returns one triplet through the registered
// memory read; the final one carries last. A read with nothing left gives status 2. A load
// after reading has begun discards the rest of the batch and opens a new one. The register
// payload_is_double (reset 1), written through cfg_we and cfg_wdata, decides at load time
// whether the full 64 payload bits are kept or only the low 32. The user must write it
// only while the block is idle; the block itself does not enforce it.
module sparse_triplet_row_col_sort
    import sts_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    // The controller sequences loads, merge passes and reads; the datapath holds the
    // memories, pointers and the output register that carries one result transaction.
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    sts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .command (s_data.command),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sts_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

// The bench drives load and read transactions into the triplet sorter and checks every result.
// It keeps its own copy of the batch, sorts it the way the block must, and queues one
// expected result for each read and for each load that is dropped.
module tb;
    import sts_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic cfg_wdata;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    sparse_triplet_row_col_sort i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // This is the bench's own copy of the sorter state.
    logic [ROW_W-1:0] batch_row [$];
    logic [COL_W-1:0] batch_col [$];
    logic [VAL_W-1:0] batch_val [$];
    bit               batch_sorted;
    int               next_out;
    bit               wide_payload;

    out_t expected_results [$];
    int   errors;
    int   cycle_count;
    int   hold_off;
    int   ready_wait;
    bit   random_stall;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The watchdog counts clock cycles and ends the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sort the batch by row, then by column. The insertion sort is stable, so
    // triplets with equal keys keep their load order.
    function automatic void sort_batch_keys();
        int j;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [VAL_W-1:0] v;
        for (int i = 1; i < batch_row.size(); i++) begin
            r = batch_row[i];
            c = batch_col[i];
            v = batch_val[i];
            j = i;
            while (j > 0 && {batch_row[j-1], batch_col[j-1]} > {r, c}) begin
                batch_row[j] = batch_row[j-1];
                batch_col[j] = batch_col[j-1];
                batch_val[j] = batch_val[j-1];
                j--;
            end
            batch_row[j] = r;
            batch_col[j] = c;
            batch_val[j] = v;
        end
    endfunction

    // Update the state copy for one accepted transaction, and queue the result that it
    // causes, if any.
    function automatic void predict_triplet(input in_t item);
        out_t res;
        res = '0;
        if (item.command == CMD_LOAD) begin
            // A load after reading has begun discards the rest of the old batch.
            if (batch_sorted) begin
                batch_row.delete();
                batch_col.delete();
                batch_val.delete();
                batch_sorted = 1'b0;
                next_out = 0;
            end
            if (batch_row.size() >= MAX_ENTRIES) begin
                res.status = STATUS_FULL;
                expected_results.push_back(res);
            end else begin
                batch_row.push_back(item.row);
                batch_col.push_back(item.col);
                batch_val.push_back(wide_payload ? item.value
                                                 : {32'd0, item.value[31:0]});
            end
            return;
        end
        if (!batch_sorted && batch_row.size() != 0) begin
            sort_batch_keys();
            batch_sorted = 1'b1;
            next_out = 0;
        end
        if (!batch_sorted || next_out >= batch_row.size()) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.out_row   = batch_row[next_out];
            res.out_col   = batch_col[next_out];
            res.out_value = batch_val[next_out];
            res.last      = (next_out + 1 == batch_row.size());
            res.status    = STATUS_OK;
            next_out++;
        end
        expected_results.push_back(res);
    endfunction

    // After every result it takes, the receiver draws a random wait when random_stall is set,
    // and it holds off for a long stretch when asked to.
    always @(posedge aclk) begin
        int wait_draw;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_off   <= 0;
            ready_wait <= 0;
        end else if (hold_off > 0) begin
            m_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (m_valid && m_ready) begin
            wait_draw = random_stall ? int'($urandom_range(0, 10)) : 0;
            ready_wait <= wait_draw;
            m_ready    <= (wait_draw == 0);
        end else if (ready_wait > 0) begin
            m_ready    <= (ready_wait == 1);
            ready_wait <= ready_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result that is accepted is compared with the oldest expectation.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.out_row !== want.out_row) begin
                    $display("%0t: out_row expected %h actual %h", $time,
                             want.out_row, m_data.out_row);
                    errors++;
                end
                if (m_data.out_col !== want.out_col) begin
                    $display("%0t: out_col expected %h actual %h", $time,
                             want.out_col, m_data.out_col);
                    errors++;
                end
                if (m_data.out_value !== want.out_value) begin
                    $display("%0t: out_value expected %h actual %h", $time,
                             want.out_value, m_data.out_value);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, m_data.last);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    // Send one transaction. The sender waits a random gap unless a gap of zero is asked for,
    // and valid stays high until the block accepts the transaction. With no gap, valid stays
    // high straight into the next transaction.
    task automatic send_triplet(input in_t item, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_triplet(item);
    endtask

    function automatic in_t make_load(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                      input logic [VAL_W-1:0] v);
        in_t item;
        item.command = CMD_LOAD;
        item.row     = r;
        item.col     = c;
        item.value   = v;
        return item;
    endfunction

    function automatic in_t make_read();
        in_t item;
        item.command = CMD_READ;
        item.row     = ROW_W'($urandom);
        item.col     = COL_W'($urandom);
        item.value   = {$urandom, $urandom};
        return item;
    endfunction

    function automatic in_t random_load();
        return make_load(ROW_W'($urandom), COL_W'($urandom), {$urandom, $urandom});
    endfunction

    // Stop offering transactions and wait until every expected result has come. Loads owe no
    // result, but each one has been taken by then, so the block is idle and stays idle until
    // the register changes.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_payload_mode(input bit wide);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= wide;
        @(posedge aclk);
        cfg_we <= 1'b0;
        wide_payload = wide;
    endtask

    // Directed cases: a read of an empty store, extreme keys, equal keys that must keep
    // their load order, reads past the end, and a load that cuts a batch short.
    task automatic test_directed();
        send_triplet(make_read(), 10);
        send_triplet(make_load(12'hFFF, 16'hFFFF, '1), 10);
        send_triplet(make_load(12'h000, 16'h0000, '0), 10);
        send_triplet(make_load(12'h005, 16'h0010, 64'h1111), 10);
        send_triplet(make_load(12'h005, 16'h0010, 64'h2222), 10);
        send_triplet(make_load(12'h005, 16'h0003, 64'hAAAA_5555_AAAA_5555), 10);
        send_triplet(make_load(12'hFFF, 16'h0000, 64'h5555_AAAA_5555_AAAA), 10);
        send_triplet(make_load(12'h000, 16'hFFFF, 64'h8000_0000_0000_0001), 10);
        repeat (9) send_triplet(make_read(), 10);
        send_triplet(make_load(12'h123, 16'h4567, 64'h89AB_CDEF_0123_4567), 10);
        send_triplet(make_load(12'h001, 16'h0002, 64'h3), 10);
        send_triplet(make_read(), 10);
        // This load comes after reading has begun, so the unread entry is discarded.
        send_triplet(make_load(12'h7FF, 16'h8000, 64'hFFFF_FFFF_0000_0000), 10);
        repeat (2) send_triplet(make_read(), 10);
    endtask

    // Well-formed batches of random size and content: loads, then reads that often run
    // past the end or stop early, with some loads drawn from a small key range so keys repeat.
    task automatic test_random_batches(input int batches, input int max_size);
        int size;
        int reads;
        for (int b = 0; b < batches; b++) begin
            size = $urandom_range(1, max_size);
            for (int i = 0; i < size; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_triplet(make_load(ROW_W'($urandom_range(0, 3)),
                                           COL_W'($urandom_range(0, 3)),
                                           {$urandom, $urandom}), 10);
                else
                    send_triplet(random_load(), 10);
            end
            reads = $urandom_range(0, 3) == 0 ? $urandom_range(0, size) : size + 1;
            repeat (reads) send_triplet(make_read(), 10);
        end
    endtask

    // The receiver holds off while loads and reads keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_off = 200;
        repeat (8) send_triplet(random_load(), 0);
        repeat (12) send_triplet(make_read(), 0);
        // The sender pauses here until every result has come.
        drain_results();
    endtask

    // Fill the store to capacity, then load more so that the overflow is dropped and
    // flagged, then read back the start of the sorted batch.
    task automatic test_full_store();
        for (int i = 0; i < MAX_ENTRIES + 3; i++)
            send_triplet(make_load(ROW_W'($urandom_range(0, 40)), COL_W'($urandom),
                                   {$urandom, $urandom}), 0);
        repeat (64) send_triplet(make_read(), 0);
    endtask

    initial begin
        errors       = 0;
        cycle_count  = 0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        random_stall = 1'b1;
        batch_sorted = 1'b0;
        next_out     = 0;
        wide_payload = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        write_payload_mode(1'b0);
        test_directed();
        test_random_batches(6, 20);
        write_payload_mode(1'b1);
        random_stall = 1'b0;
        test_random_batches(4, 20);
        random_stall = 1'b1;
        test_full_store();
        write_payload_mode(1'b0);
        test_random_batches(3, 12);
        write_payload_mode(1'b1);
        test_random_batches(3, 12);

        drain_results();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sts_ctrl.sv
hw/rtl/sts_dp.sv
hw/rtl/sparse_triplet_row_col_sort.sv
tb/tb.sv
